// ----- design/fixed_point_square_root_core_macros.svh -----
// Assertion macros shared by the square root checker
`ifndef FIXED_POINT_SQUARE_ROOT_CORE_MACROS_SVH
`define FIXED_POINT_SQUARE_ROOT_CORE_MACROS_SVH

// implication checked outside reset
`define FSR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("square root check failed");

// next-cycle implication checked at every edge
`define FSR_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("square root check failed");

`endif

// ----- design/fsr_pkg.sv -----
// Package with shared constants of the fixed-point square root core
`timescale 1ns / 1ps
package fsr_pkg;

  localparam int FIELD_BITS      = 32;
  localparam int WORD_BITS_DEF   = 32;
  localparam int SCALE_SHIFT_DEF = 8;

  function automatic int fsr_rounds(input int word_bits);
    return (word_bits + 1) / 2;
  endfunction

endpackage

// ----- design/fsr_cell.sv -----
// One round of the restoring square root as a registered cell
`timescale 1ns / 1ps
module fsr_cell #(
  parameter int ROUNDS   = 16,
  parameter int PAD_BITS = 2 * ROUNDS,
  parameter int REM_BITS = ROUNDS + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  logic [PAD_BITS-1:0] opnd_in,
  input  logic [REM_BITS-1:0] rem_in,
  input  logic [ROUNDS-1:0]   acc_in,
  output logic                valid_out,
  output logic [PAD_BITS-1:0] opnd_out,
  output logic [REM_BITS-1:0] rem_out,
  output logic [ROUNDS-1:0]   acc_out
);

  logic [REM_BITS-1:0] rem_sh;
  logic [REM_BITS-1:0] trial;
  logic [ROUNDS-1:0]   acc_sh;
  logic [REM_BITS-1:0] rem_next;
  logic [ROUNDS-1:0]   acc_next;
  logic [PAD_BITS-1:0] opnd_next;

  always_comb begin
    rem_sh    = {rem_in[REM_BITS-3:0], opnd_in[PAD_BITS-1 -: 2]};
    acc_sh    = {acc_in[ROUNDS-2:0], 1'b0};
    trial     = REM_BITS'({acc_sh, 1'b1});
    opnd_next = {opnd_in[PAD_BITS-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_next = rem_sh - trial;
      acc_next = acc_sh | ROUNDS'(1);
    end else begin
      rem_next = rem_sh;
      acc_next = acc_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    opnd_out <= opnd_next;
    rem_out  <= rem_next;
    acc_out  <= acc_next;
  end

endmodule

// ----- design/fixed_point_square_root_core.sv -----
// Top level of the pipelined fixed-point square root core
//
//   channel   handshake         payload   width
//   operand   start / busy      value     32
//   result    done (strobe)     root      32
//
// One operand is accepted every cycle while busy is low; the result passes through the cell chain,
// ROUNDS = (WORD_BITS + 1) / 2 cells, one cell per root bit, and then through the output register.
// busy is high only during reset; rst clears every valid bit of the chain at once.
// done is a one-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps
module fixed_point_square_root_core #(
  parameter int WORD_BITS   = fsr_pkg::WORD_BITS_DEF,
  parameter int SCALE_SHIFT = fsr_pkg::SCALE_SHIFT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [fsr_pkg::FIELD_BITS-1:0] value,
  output logic                          done,
  output logic [fsr_pkg::FIELD_BITS-1:0] root
);

  import fsr_pkg::*;

  localparam int ROUNDS   = fsr_rounds(WORD_BITS);
  localparam int PAD_BITS = 2 * ROUNDS;
  localparam int REM_BITS = ROUNDS + 2;

  logic                valid_c [0:ROUNDS];
  logic [PAD_BITS-1:0] opnd_c  [0:ROUNDS];
  logic [REM_BITS-1:0] rem_c   [0:ROUNDS];
  logic [ROUNDS-1:0]   acc_c   [0:ROUNDS];

  logic [WORD_BITS-1:0]  scaled;
  logic [FIELD_BITS-1:0] root_next;

  assign busy       = rst;
  assign valid_c[0] = start & ~busy;
  assign opnd_c[0]  = PAD_BITS'(WORD_BITS'(value));
  assign rem_c[0]   = '0;
  assign acc_c[0]   = '0;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
    fsr_cell #(
      .ROUNDS   (ROUNDS),
      .PAD_BITS (PAD_BITS),
      .REM_BITS (REM_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_c[g]),
      .opnd_in   (opnd_c[g]),
      .rem_in    (rem_c[g]),
      .acc_in    (acc_c[g]),
      .valid_out (valid_c[g+1]),
      .opnd_out  (opnd_c[g+1]),
      .rem_out   (rem_c[g+1]),
      .acc_out   (acc_c[g+1])
    );
  end

  always_comb begin
    scaled    = WORD_BITS'(acc_c[ROUNDS]) << SCALE_SHIFT;
    root_next = FIELD_BITS'(scaled);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_c[ROUNDS];
    end
    root <= root_next;
  end

endmodule

// ----- design/fsr_checker.sv -----
// Port-level checker for the fixed-point square root core and its bind
`timescale 1ns / 1ps
`include "fixed_point_square_root_core_macros.svh"
module fsr_checker #(
  parameter int WORD_BITS = fsr_pkg::WORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [fsr_pkg::FIELD_BITS-1:0] value,
  input logic                          done,
  input logic [fsr_pkg::FIELD_BITS-1:0] root
);

  import fsr_pkg::*;

  localparam int LATENCY = fsr_rounds(WORD_BITS) + 1;

  logic accept;
  assign accept = start & ~busy;

  `FSR_ASSERT_IMPLY(a_result_follows, clk, rst, accept, ##LATENCY done)
  `FSR_ASSERT_IMPLY(a_no_spurious, clk, rst, !accept, ##LATENCY !done)
  `FSR_ASSERT_IMPLY(a_zero_root, clk, rst, accept && (value == '0), ##LATENCY (root == '0))
  `FSR_ASSERT_NEXT(a_reset_quiet, clk, rst, !done)

endmodule

bind fixed_point_square_root_core fsr_checker #(
  .WORD_BITS (WORD_BITS)
) u_fsr_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .value (value),
  .done  (done),
  .root  (root)
);

// ----- dv/fixed_point_square_root_checker.sv -----
// Checker that predicts and compares every square root transaction of the core
`timescale 1ns / 1ps
module fixed_point_square_root_checker #(
  parameter int WORD_BITS   = fsr_pkg::WORD_BITS_DEF,
  parameter int SCALE_SHIFT = fsr_pkg::SCALE_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [fsr_pkg::FIELD_BITS-1:0] value,
  input  logic                           done,
  input  logic [fsr_pkg::FIELD_BITS-1:0] root,
  output int                             errors,
  output int                             outstanding
);

  import fsr_pkg::FIELD_BITS;

  logic [FIELD_BITS-1:0] pending_roots[$];

  function automatic logic [FIELD_BITS-1:0] predict_root(input logic [FIELD_BITS-1:0] operand);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] trial;
    logic [63:0] scaled;
    int          rounds;
    int          pos;
    mask   = (WORD_BITS >= 64) ? '1 : ((64'd1 << WORD_BITS) - 64'd1);
    x      = 64'(operand) & mask;
    rounds = (WORD_BITS + 1) / 2;
    rem    = '0;
    acc    = '0;
    for (int i = 0; i < rounds; i++) begin
      pos = 2 * (rounds - 1 - i);
      rem = (rem << 2) + ((pos < 64) ? ((x >> pos) & 64'd3) : 64'd0);
      acc = acc << 1;
      trial = (acc << 1) + 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        acc = acc + 64'd1;
      end
    end
    scaled = (SCALE_SHIFT >= 64) ? 64'd0 : (acc << SCALE_SHIFT);
    scaled = scaled & mask;
    return scaled[FIELD_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    logic [FIELD_BITS-1:0] want;
    if (!rst) begin
      if (done) begin
        if (pending_roots.size() == 0) begin
          $error("root: unexpected result, actual %h", root);
          errors <= errors + 1;
        end else begin
          want = pending_roots.pop_front();
          if (root !== want) begin
            $error("root: expected %h, actual %h", want, root);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) begin
        pending_roots.push_back(predict_root(value));
      end
    end
    outstanding <= pending_roots.size();
  end

endmodule

// ----- dv/fixed_point_square_root_core_tb.sv -----
// Top of the square root core testbench: clock, reset, operand stimulus and verdict
`timescale 1ns / 1ps
module fixed_point_square_root_core_tb;

  import fsr_pkg::FIELD_BITS;

  localparam int WORD_BITS   = fsr_pkg::WORD_BITS_DEF;
  localparam int SCALE_SHIFT = fsr_pkg::SCALE_SHIFT_DEF;
  localparam int LATENCY     = (WORD_BITS + 1) / 2 + 1;
  localparam int RANDOM_OPS  = 1930;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [FIELD_BITS-1:0] value;
  logic                  done;
  logic [FIELD_BITS-1:0] root;
  int                    errors;
  int                    outstanding;
  bit                    no_gaps;

  fixed_point_square_root_core #(
    .WORD_BITS  (WORD_BITS),
    .SCALE_SHIFT(SCALE_SHIFT)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .value(value),
    .done (done),
    .root (root)
  );

  fixed_point_square_root_checker #(
    .WORD_BITS  (WORD_BITS),
    .SCALE_SHIFT(SCALE_SHIFT)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .done       (done),
    .root       (root),
    .errors     (errors),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic drive_operand(input logic [FIELD_BITS-1:0] operand);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= operand;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [FIELD_BITS-1:0] random_operand();
    logic [63:0] n;
    logic [63:0] sq;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5: begin
        n  = 64'($urandom_range(0, 65535));
        sq = n * n;
        return sq[FIELD_BITS-1:0];
      end
      6: begin
        n  = 64'($urandom_range(1, 65535));
        sq = n * n - 64'd1;
        return sq[FIELD_BITS-1:0];
      end
      7: begin
        n  = 64'($urandom_range(0, 65535));
        sq = n * n + 2 * n;
        return sq[FIELD_BITS-1:0];
      end
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    logic [FIELD_BITS-1:0] directed[];
    directed = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
      32'h0000_0004, 32'h0000_0008, 32'h0000_0009, 32'h0000_00FF,
      32'h0001_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFE_0000,
      32'hFFFE_0001, 32'hFFFE_0002, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
      32'h0000_FFFF, 32'hC000_0000, 32'h0000_0010
    };
    rst     <= 1'b1;
    start   <= 1'b0;
    value   <= '0;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) drive_operand(directed[i]);
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      drive_operand(random_operand());
    end
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("simulation failed");
    $finish;
  end

endmodule
